// ===== rtl/apt_pkg.sv =====
// shared constants and types for the affine point transform
`timescale 1ns / 1ps

package apt_pkg;

    // default fixed-point format
    localparam int DEF_FRACTION_BITS = 16;
    localparam int DEF_WORD_BITS     = 32;

    // port widths
    localparam int PORT_BITS    = 32;
    localparam int CFG_BITS     = 64;
    localparam int CFG_IDX_BITS = 4;
    localparam int HALF_BITS    = 32;
    localparam int COEF_H_BITS  = 34;

    // coefficient register count (full 64-bit ones)
    localparam int NUM_COEF64 = 7;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_C = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_D = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_E = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_F = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_G = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_H = 4'd7;

    // mode bits in coef_h
    localparam int H_IDENT_BIT = 33;
    localparam int H_RS_BIT    = 32;

    // reset values: identity matrix, zero translate, unit scale, identity mode
    localparam logic [CFG_BITS-1:0] COEF_RESET [NUM_COEF64] = '{
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0001_0000
    };
    localparam logic [COEF_H_BITS-1:0] COEF_H_RESET = 34'h3_0001_0000;

    // control that travels with each item down the pipeline
    typedef struct packed {
        logic valid;
        logic ident;
        logic rs;
    } t_ctl;

endpackage

// ===== rtl/apt_scale.sv =====
// stage one: per-axis scale products
`timescale 1ns / 1ps

module apt_scale #(
    parameter int WORD_BITS = apt_pkg::DEF_WORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  apt_pkg::t_ctl                 i_ctl,
    input  logic signed [WORD_BITS-1:0]   i_p   [3],
    input  logic signed [WORD_BITS-1:0]   i_s   [3],
    output apt_pkg::t_ctl                 o_ctl,
    output logic signed [WORD_BITS-1:0]   o_p   [3],
    output logic signed [2*WORD_BITS-1:0] o_sp  [3]
);
    import apt_pkg::*;

    localparam int PW = 2 * WORD_BITS;

    t_ctl                   r_ctl;
    logic signed [WORD_BITS-1:0] r_p  [3];
    logic signed [PW-1:0]   r_sp [3];
    logic signed [PW-1:0]   n_sp [3];

    // full-width scale products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sp[i] = i_s[i] * i_p[i];
        end
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_p[i]  <= i_p[i];
            r_sp[i] <= n_sp[i];
        end
    end

    assign o_ctl = r_ctl;
    assign o_p   = r_p;
    assign o_sp  = r_sp;

endmodule

// ===== rtl/apt_mat.sv =====
// stage two: scale select and nine matrix products
`timescale 1ns / 1ps

module apt_mat #(
    parameter int FRACTION_BITS = apt_pkg::DEF_FRACTION_BITS,
    parameter int WORD_BITS     = apt_pkg::DEF_WORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  apt_pkg::t_ctl                 i_ctl,
    input  logic signed [WORD_BITS-1:0]   i_p    [3],
    input  logic signed [2*WORD_BITS-1:0] i_sp   [3],
    input  logic signed [WORD_BITS-1:0]   i_m    [9],
    output apt_pkg::t_ctl                 o_ctl,
    output logic signed [WORD_BITS-1:0]   o_p    [3],
    output logic signed [2*WORD_BITS-1:0] o_prod [9]
);
    import apt_pkg::*;

    localparam int PW = 2 * WORD_BITS;
    localparam int EW = PW + FRACTION_BITS;

    t_ctl                        r_ctl;
    logic signed [WORD_BITS-1:0] r_p    [3];
    logic signed [PW-1:0]        r_prod [9];
    logic signed [PW-1:0]        n_prod [9];
    logic signed [EW-1:0]        w_ext  [3];
    logic signed [WORD_BITS-1:0] w_x    [3];

    // shift scaled product down and wrap, or pass raw point
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ext[i] = EW'(i_sp[i]);
            w_x[i]   = i_ctl.rs ? w_ext[i][FRACTION_BITS+WORD_BITS-1:FRACTION_BITS]
                                : i_p[i];
        end
    end

    // matrix products, row-major
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[r*3+c] = i_m[r*3+c] * w_x[c];
            end
        end
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_p[i] <= i_p[i];
        end
        for (int k = 0; k < 9; k++) begin
            r_prod[k] <= n_prod[k];
        end
    end

    assign o_ctl  = r_ctl;
    assign o_p    = r_p;
    assign o_prod = r_prod;

endmodule

// ===== rtl/apt_sum.sv =====
// stage three: row sums plus translate, identity bypass
`timescale 1ns / 1ps

module apt_sum #(
    parameter int FRACTION_BITS = apt_pkg::DEF_FRACTION_BITS,
    parameter int WORD_BITS     = apt_pkg::DEF_WORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  apt_pkg::t_ctl                 i_ctl,
    input  logic signed [WORD_BITS-1:0]   i_p    [3],
    input  logic signed [2*WORD_BITS-1:0] i_prod [9],
    input  logic signed [WORD_BITS-1:0]   i_t    [3],
    output logic                          o_valid,
    output logic signed [WORD_BITS-1:0]   o_q    [3]
);
    import apt_pkg::*;

    localparam int PW = 2 * WORD_BITS;
    localparam int EW = PW + FRACTION_BITS;

    logic                        r_valid;
    logic signed [WORD_BITS-1:0] r_q   [3];
    logic signed [WORD_BITS-1:0] n_q   [3];
    logic signed [EW-1:0]        w_ext [9];
    logic signed [WORD_BITS-1:0] w_mw  [9];

    // shift each product down and wrap to a word
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_ext[k] = EW'(i_prod[k]);
            w_mw[k]  = w_ext[k][FRACTION_BITS+WORD_BITS-1:FRACTION_BITS];
        end
    end

    // wrapped row sums, or raw point in identity mode
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (i_ctl.ident) begin
                n_q[r] = i_p[r];
            end else begin
                n_q[r] = w_mw[r*3] + w_mw[r*3+1] + w_mw[r*3+2] + i_t[r];
            end
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r_q[r] <= n_q[r];
        end
    end

    assign o_valid = r_valid;
    assign o_q     = r_q;

endmodule

// ===== rtl/affine_point_transform_top.sv =====
// top level of the affine point transform: config registers and pipeline
// a point accepted at one edge passes the u_scale, u_mat and u_sum registers in turn, then sits on
// o_qx/o_qy/o_qz with o_valid for one cycle
// throughput: one point per cycle, set by the three-stage multiply/add pipeline
// busy never rises; the receiver cannot stall, so results stream out as they finish
// reset clears the pipeline valid bits and reloads the identity configuration
`timescale 1ns / 1ps

module affine_point_transform_top #(
    parameter int FRACTION_BITS = apt_pkg::DEF_FRACTION_BITS,
    parameter int WORD_BITS     = apt_pkg::DEF_WORD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [apt_pkg::PORT_BITS-1:0] i_px,
    input  logic signed [apt_pkg::PORT_BITS-1:0] i_py,
    input  logic signed [apt_pkg::PORT_BITS-1:0] i_pz,
    output logic                                o_valid,
    output logic signed [apt_pkg::PORT_BITS-1:0] o_qx,
    output logic signed [apt_pkg::PORT_BITS-1:0] o_qy,
    output logic signed [apt_pkg::PORT_BITS-1:0] o_qz,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [apt_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [apt_pkg::CFG_BITS-1:0]        i_cfg_data
);
    import apt_pkg::*;

    localparam int PW = 2 * WORD_BITS;

    logic [CFG_BITS-1:0]    r_coef [NUM_COEF64];
    logic [COEF_H_BITS-1:0] r_coef_h;

    logic signed [WORD_BITS-1:0] w_m  [9];
    logic signed [WORD_BITS-1:0] w_t  [3];
    logic signed [WORD_BITS-1:0] w_s  [3];
    logic signed [WORD_BITS-1:0] w_p  [3];
    t_ctl                        w_ctl0;

    t_ctl                        w_ctl1;
    logic signed [WORD_BITS-1:0] w_p1   [3];
    logic signed [PW-1:0]        w_sp1  [3];
    t_ctl                        w_ctl2;
    logic signed [WORD_BITS-1:0] w_p2   [3];
    logic signed [PW-1:0]        w_prod [9];
    logic signed [WORD_BITS-1:0] w_q    [3];

    // configuration writes; out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef   <= COEF_RESET;
            r_coef_h <= COEF_H_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COEF_A, REG_COEF_B, REG_COEF_C, REG_COEF_D,
                REG_COEF_E, REG_COEF_F, REG_COEF_G: begin
                    r_coef[i_cfg_index[2:0]] <= i_cfg_data;
                end
                REG_COEF_H: begin
                    r_coef_h <= i_cfg_data[COEF_H_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // unpack coefficient words, high half first
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            if (k % 2 == 0) begin
                w_m[k] = r_coef[k/2][HALF_BITS+WORD_BITS-1:HALF_BITS];
            end else begin
                w_m[k] = r_coef[k/2][WORD_BITS-1:0];
            end
        end
        w_t[0] = r_coef[REG_COEF_E[2:0]][WORD_BITS-1:0];
        w_t[1] = r_coef[REG_COEF_F[2:0]][HALF_BITS+WORD_BITS-1:HALF_BITS];
        w_t[2] = r_coef[REG_COEF_F[2:0]][WORD_BITS-1:0];
        w_s[0] = r_coef[REG_COEF_G[2:0]][HALF_BITS+WORD_BITS-1:HALF_BITS];
        w_s[1] = r_coef[REG_COEF_G[2:0]][WORD_BITS-1:0];
        w_s[2] = r_coef_h[WORD_BITS-1:0];
    end

    // input item, narrowed to the word width
    assign w_p[0] = i_px[WORD_BITS-1:0];
    assign w_p[1] = i_py[WORD_BITS-1:0];
    assign w_p[2] = i_pz[WORD_BITS-1:0];

    assign w_ctl0.valid = start & ~busy;
    assign w_ctl0.ident = r_coef_h[H_IDENT_BIT];
    assign w_ctl0.rs    = r_coef_h[H_RS_BIT];

    // pipeline stages
    apt_scale #(
        .WORD_BITS (WORD_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl0),
        .i_p     (w_p),
        .i_s     (w_s),
        .o_ctl   (w_ctl1),
        .o_p     (w_p1),
        .o_sp    (w_sp1)
    );

    apt_mat #(
        .FRACTION_BITS (FRACTION_BITS),
        .WORD_BITS     (WORD_BITS)
    ) u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl1),
        .i_p     (w_p1),
        .i_sp    (w_sp1),
        .i_m     (w_m),
        .o_ctl   (w_ctl2),
        .o_p     (w_p2),
        .o_prod  (w_prod)
    );

    apt_sum #(
        .FRACTION_BITS (FRACTION_BITS),
        .WORD_BITS     (WORD_BITS)
    ) u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl2),
        .i_p     (w_p2),
        .i_prod  (w_prod),
        .i_t     (w_t),
        .o_valid (o_valid),
        .o_q     (w_q)
    );

    // sign-extend results to the port width
    assign o_qx = PORT_BITS'(w_q[0]);
    assign o_qy = PORT_BITS'(w_q[1]);
    assign o_qz = PORT_BITS'(w_q[2]);

endmodule
